@@ design/quaternion_nlerp_unit_assert.svh @@
// Assertion macros for the quaternion nlerp unit checker.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef QUATERNION_NLERP_UNIT_ASSERT_SVH
`define QUATERNION_NLERP_UNIT_ASSERT_SVH

// Implication checked on every rising edge outside reset.
`define QNL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion nlerp check failed");

// Invariant checked on every rising edge outside reset.
`define QNL_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("quaternion nlerp check failed");

`endif

@@ design/qnl_pkg.sv @@
// Shared types and constants for the quaternion nlerp pipeline.
// No dependencies.
package qnl_pkg;

    localparam logic [15:0] ONE_T = 16'd32768;   // t = 1.0 in Q1.15
    localparam int FRAC_OUT = 14;                 // output fraction bits
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES = 15;

    typedef logic signed [15:0] q14_t;
    typedef logic [3:0][31:0] vec_t;

    typedef struct packed {
        logic        valid;
        logic [62:0] sumsq;
        vec_t        v;
    } sq_beat_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] mag;
        vec_t        v;
    } root_beat_t;

endpackage

@@ design/qnl_blend.sv @@
// Front end: dot sign, weighted blend and squared length, five stages.
// Depends on qnl_pkg.
module qnl_blend (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [3:0][15:0]  start_q,
    input  logic [3:0][15:0]  end_q,
    input  logic [15:0]       blend,
    output qnl_pkg::sq_beat_t beat
);
    import qnl_pkg::*;

    logic [15:0] t_clamp;
    logic [15:0] wa;

    logic        s1_valid_reg;
    vec_t        s1_se_reg, s1_ws_reg, s1_te_reg;
    vec_t        s1_se_next, s1_ws_next, s1_te_next;
    logic        s2_valid_reg;
    vec_t        s2_v_reg, s2_v_next;
    logic [33:0] dot;
    logic        s3_valid_reg;
    vec_t        s3_v_reg;
    logic [3:0][60:0] s3_sq_reg, s3_sq_next;
    logic        s4_valid_reg;
    vec_t        s4_v_reg;
    logic [1:0][61:0] s4_pr_reg, s4_pr_next;
    logic        s5_valid_reg;
    vec_t        s5_v_reg;
    logic [62:0] s5_sum_reg, s5_sum_next;

    assign t_clamp = (blend > ONE_T) ? ONE_T : blend;
    assign wa      = ONE_T - t_clamp;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            s1_se_next[i] = 32'($signed(start_q[i]) * $signed(end_q[i]));
            s1_ws_next[i] = 32'($signed({1'b0, wa}) * $signed(start_q[i]));
            s1_te_next[i] = 32'($signed({1'b0, t_clamp}) * $signed(end_q[i]));
        end
    end

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
            dot = dot + {{2{s1_se_reg[i][31]}}, s1_se_reg[i]};
        // take the short way round: flip the end weight on a negative dot
        for (int i = 0; i < 4; i++)
            s2_v_next[i] = s1_ws_reg[i] + (dot[33] ? (32'd0 - s1_te_reg[i]) : s1_te_reg[i]);
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            s3_sq_next[i] = 61'($signed(s2_v_reg[i]) * $signed(s2_v_reg[i]));
        s4_pr_next[0] = {1'b0, s3_sq_reg[0]} + {1'b0, s3_sq_reg[1]};
        s4_pr_next[1] = {1'b0, s3_sq_reg[2]} + {1'b0, s3_sq_reg[3]};
        s5_sum_next   = {1'b0, s4_pr_reg[0]} + {1'b0, s4_pr_reg[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_se_reg  <= s1_se_next;
        s1_ws_reg  <= s1_ws_next;
        s1_te_reg  <= s1_te_next;
        s2_v_reg   <= s2_v_next;
        s3_v_reg   <= s2_v_reg;
        s3_sq_reg  <= s3_sq_next;
        s4_v_reg   <= s3_v_reg;
        s4_pr_reg  <= s4_pr_next;
        s5_v_reg   <= s4_v_reg;
        s5_sum_reg <= s5_sum_next;
    end

    assign beat.valid = s5_valid_reg;
    assign beat.sumsq = s5_sum_reg;
    assign beat.v     = s5_v_reg;

endmodule

@@ design/qnl_sqrt.sv @@
// Pipelined integer square root of the squared length, one result bit a stage.
// Depends on qnl_pkg.
module qnl_sqrt (
    input  logic                clk,
    input  logic                rst_n,
    input  qnl_pkg::sq_beat_t   in_beat,
    output qnl_pkg::root_beat_t out_beat
);
    import qnl_pkg::*;

    logic        valid_reg [SQRT_STAGES];
    logic [63:0] rem_reg   [SQRT_STAGES];
    logic [63:0] res_reg   [SQRT_STAGES];
    vec_t        v_reg     [SQRT_STAGES];

    for (genvar j = 0; j < SQRT_STAGES; j++)
    begin : g_stage
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

        logic        valid_in;
        logic [63:0] rem_in, res_in, trial, rem_next, res_next;
        vec_t        v_in;

        if (j == 0)
        begin : g_first
            assign valid_in = in_beat.valid;
            assign rem_in   = {1'b0, in_beat.sumsq};
            assign res_in   = '0;
            assign v_in     = in_beat.v;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign res_in   = res_reg[j-1];
            assign v_in     = v_reg[j-1];
        end

        assign trial = res_in + BIT;

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else
                valid_reg[j] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            res_reg[j] <= res_next;
            v_reg[j]   <= v_in;
        end
    end

    assign out_beat.valid = valid_reg[SQRT_STAGES-1];
    assign out_beat.mag   = res_reg[SQRT_STAGES-1][31:0];
    assign out_beat.v     = v_reg[SQRT_STAGES-1];

endmodule

@@ design/qnl_div.sv @@
// Pipelined rounding divide of each component by the magnitude, plus sign
// and zero-length handling and the output register. Depends on qnl_pkg.
module qnl_div (
    input  logic                clk,
    input  logic                rst_n,
    input  qnl_pkg::root_beat_t in_beat,
    output logic                done,
    output logic [3:0][15:0]    out_q,
    output logic                zero_flag
);
    import qnl_pkg::*;

    logic             p_valid_reg, p_zero_reg;
    logic [31:0]      p_m_reg;
    logic [3:0]       p_neg_reg;
    logic [3:0][46:0] p_num_reg, p_num_next;
    logic [3:0][30:0] mag;

    logic             valid_reg [DIV_STAGES];
    logic             zero_reg  [DIV_STAGES];
    logic [31:0]      m_reg     [DIV_STAGES];
    logic [3:0]       neg_reg   [DIV_STAGES];
    logic [3:0][46:0] rem_reg   [DIV_STAGES];
    logic [3:0][14:0] q_reg     [DIV_STAGES];

    logic             done_reg, zero_out_reg;
    logic [3:0][15:0] out_reg, out_next;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag[i] = in_beat.v[i][31] ? 31'(32'd0 - in_beat.v[i]) : in_beat.v[i][30:0];
            // numerator |v| * 2^14 plus half the divisor for round to nearest
            p_num_next[i] = {2'b0, mag[i], {FRAC_OUT{1'b0}}} + {15'b0, in_beat.mag >> 1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else
            p_valid_reg <= in_beat.valid;
    end

    always_ff @(posedge clk)
    begin
        p_zero_reg <= (in_beat.mag == 32'd0);
        p_m_reg    <= in_beat.mag;
        for (int i = 0; i < 4; i++)
            p_neg_reg[i] <= in_beat.v[i][31];
        p_num_reg  <= p_num_next;
    end

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int K = DIV_STAGES - 1 - j;

        logic             valid_in, zero_in;
        logic [31:0]      m_in;
        logic [3:0]       neg_in;
        logic [3:0][46:0] rem_in, rem_next;
        logic [3:0][14:0] q_in, q_next;
        logic [46:0]      dsh;

        if (j == 0)
        begin : g_first
            assign valid_in = p_valid_reg;
            assign zero_in  = p_zero_reg;
            assign m_in     = p_m_reg;
            assign neg_in   = p_neg_reg;
            assign rem_in   = p_num_reg;
            assign q_in     = '0;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[j-1];
            assign zero_in  = zero_reg[j-1];
            assign m_in     = m_reg[j-1];
            assign neg_in   = neg_reg[j-1];
            assign rem_in   = rem_reg[j-1];
            assign q_in     = q_reg[j-1];
        end

        assign dsh = {15'b0, m_in} << K;

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                q_next[i] = q_in[i];
                if (rem_in[i] >= dsh)
                begin
                    rem_next[i]  = rem_in[i] - dsh;
                    q_next[i][K] = 1'b1;
                end
                else
                    rem_next[i] = rem_in[i];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else
                valid_reg[j] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            zero_reg[j] <= zero_in;
            m_reg[j]    <= m_in;
            neg_reg[j]  <= neg_in;
            rem_reg[j]  <= rem_next;
            q_reg[j]    <= q_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            if (zero_reg[DIV_STAGES-1])
                out_next[i] = '0;
            else if (neg_reg[DIV_STAGES-1][i])
                out_next[i] = 16'd0 - {1'b0, q_reg[DIV_STAGES-1][i]};
            else
                out_next[i] = {1'b0, q_reg[DIV_STAGES-1][i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= valid_reg[DIV_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        zero_out_reg <= zero_reg[DIV_STAGES-1];
    end

    assign done      = done_reg;
    assign out_q     = out_reg;
    assign zero_flag = zero_out_reg;

endmodule

@@ design/quaternion_nlerp_unit.sv @@
// Quaternion nlerp unit: blend of two quaternions, normalized to unit length.
// Depends on qnl_pkg, qnl_blend, qnl_sqrt and qnl_div.
//
// Usage:
//   Drive start_* (Q2.14), end_* (Q2.14) and blend (Q1.15, 32768 = 1.0, larger
//   values act as 1.0) and raise start for one cycle per beat. busy stays low,
//   so a new beat may be issued every cycle; one beat per cycle sustained.
//   Each beat returns one result: done is high for exactly one cycle with
//   out_x..out_w (Q2.14) and zero_magnitude valid in that cycle.
//   The pipeline runs through the blend front end, the 32-stage square root
//   (one root bit per stage) and the 15-stage divider (one quotient bit per
//   stage), with a register before and one after the divider.
//   A zero-length blend gives all-zero outputs with zero_magnitude high.
//   Reset (rst_n low) empties the pipeline; beats in flight are dropped.
//   The receiver has no way to stall: results must be taken as they come.
module quaternion_nlerp_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  qnl_pkg::q14_t start_x,
    input  qnl_pkg::q14_t start_y,
    input  qnl_pkg::q14_t start_z,
    input  qnl_pkg::q14_t start_w,
    input  qnl_pkg::q14_t end_x,
    input  qnl_pkg::q14_t end_y,
    input  qnl_pkg::q14_t end_z,
    input  qnl_pkg::q14_t end_w,
    input  logic [15:0]   blend,
    output logic          done,
    output qnl_pkg::q14_t out_x,
    output qnl_pkg::q14_t out_y,
    output qnl_pkg::q14_t out_z,
    output qnl_pkg::q14_t out_w,
    output logic          zero_magnitude
);
    import qnl_pkg::*;

    logic [3:0][15:0] start_q, end_q, out_q;
    sq_beat_t         sq_beat;
    root_beat_t       root_beat;

    assign busy    = 1'b0;
    assign start_q = {start_w, start_z, start_y, start_x};
    assign end_q   = {end_w, end_z, end_y, end_x};

    qnl_blend u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start & ~busy),
        .start_q  (start_q),
        .end_q    (end_q),
        .blend    (blend),
        .beat     (sq_beat)
    );

    qnl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (sq_beat),
        .out_beat (root_beat)
    );

    qnl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_beat   (root_beat),
        .done      (done),
        .out_q     (out_q),
        .zero_flag (zero_magnitude)
    );

    assign out_x = out_q[0];
    assign out_y = out_q[1];
    assign out_z = out_q[2];
    assign out_w = out_q[3];

endmodule

@@ design/qnl_check.sv @@
// Port-level checker for the quaternion nlerp unit and its bind.
// Depends on quaternion_nlerp_unit_assert.svh.
`include "quaternion_nlerp_unit_assert.svh"

module qnl_check (
    input logic               clk,
    input logic               rst_n,
    input logic               busy,
    input logic               done,
    input logic signed [15:0] out_x,
    input logic signed [15:0] out_y,
    input logic signed [15:0] out_z,
    input logic signed [15:0] out_w,
    input logic               zero_magnitude
);

    logic all_zero;
    logic in_range;

    assign all_zero = (out_x == 16'sd0) && (out_y == 16'sd0) &&
                      (out_z == 16'sd0) && (out_w == 16'sd0);
    assign in_range = (out_x <= 16'sd16384) && (out_x >= -16'sd16384) &&
                      (out_y <= 16'sd16384) && (out_y >= -16'sd16384) &&
                      (out_z <= 16'sd16384) && (out_z >= -16'sd16384) &&
                      (out_w <= 16'sd16384) && (out_w >= -16'sd16384);

    `QNL_ASSERT_ALWAYS(a_never_busy, !busy)
    `QNL_ASSERT_IMPL(a_zero_gives_zero, done && zero_magnitude, all_zero)
    // a result of nonzero length must have at least one nonzero component
    `QNL_ASSERT_IMPL(a_nonzero_has_length, done && !zero_magnitude, !all_zero)
    `QNL_ASSERT_IMPL(a_unit_range, done, in_range)

endmodule

bind quaternion_nlerp_unit qnl_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .busy           (busy),
    .done           (done),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_z          (out_z),
    .out_w          (out_w),
    .zero_magnitude (zero_magnitude)
);
